/* sv/assert_macros.svh */
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* sv/osf6502_pkg.sv */
package osf6502_pkg;

	localparam int BYTE_W = 8;
	localparam int MNEM_W = 6;
	localparam int MODE_W = 4;
	localparam int OPND_W = 16;
	localparam int LEN_W  = 2;

	// Addressing modes.
	localparam logic [MODE_W-1:0] MD_ACC = 4'd0;
	localparam logic [MODE_W-1:0] MD_IMM = 4'd1;
	localparam logic [MODE_W-1:0] MD_ABS = 4'd2;
	localparam logic [MODE_W-1:0] MD_ZP  = 4'd3;
	localparam logic [MODE_W-1:0] MD_ZPX = 4'd4;
	localparam logic [MODE_W-1:0] MD_ZPY = 4'd5;
	localparam logic [MODE_W-1:0] MD_ABX = 4'd6;
	localparam logic [MODE_W-1:0] MD_ABY = 4'd7;
	localparam logic [MODE_W-1:0] MD_IMP = 4'd8;
	localparam logic [MODE_W-1:0] MD_REL = 4'd9;
	localparam logic [MODE_W-1:0] MD_IZX = 4'd10;
	localparam logic [MODE_W-1:0] MD_IZY = 4'd11;
	localparam logic [MODE_W-1:0] MD_IND = 4'd12;

	// Mnemonics in alphabetical order, as the record channel numbers them.
	typedef enum logic [MNEM_W-1:0] {
		MN_ADC, MN_AND, MN_ASL, MN_BCC, MN_BCS, MN_BEQ, MN_BIT, MN_BMI,
		MN_BNE, MN_BPL, MN_BRK, MN_BVC, MN_BVS, MN_CLC, MN_CLD, MN_CLI,
		MN_CLV, MN_CMP, MN_CPX, MN_CPY, MN_DEC, MN_DEX, MN_DEY, MN_EOR,
		MN_INC, MN_INX, MN_INY, MN_JMP, MN_JSR, MN_LDA, MN_LDX, MN_LDY,
		MN_LSR, MN_NOP, MN_ORA, MN_PHA, MN_PHP, MN_PLA, MN_PLP, MN_ROL,
		MN_ROR, MN_RTI, MN_RTS, MN_SBC, MN_SEC, MN_SED, MN_SEI, MN_STA,
		MN_STX, MN_STY, MN_TAX, MN_TAY, MN_TSX, MN_TXA, MN_TXS, MN_TYA
	} mnemonic_t;

	// Record kinds.
	localparam logic KIND_INSTR = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	// Instruction lengths in bytes.
	localparam logic [LEN_W-1:0] LEN_ONE   = 2'd1;
	localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

	// Operand bytes still expected; zero means the next byte is an opcode.
	localparam logic [1:0] NEED_OPCODE = 2'd0;
	localparam logic [1:0] NEED_ONE    = 2'd1;
	localparam logic [1:0] NEED_TWO    = 2'd2;

	typedef struct packed {
		logic              known;
		logic [MNEM_W-1:0] mnem;
		logic [MODE_W-1:0] mode;
	} op_entry_t;

	typedef struct packed {
		logic              record_kind;
		logic [BYTE_W-1:0] opcode_byte;
		logic [MNEM_W-1:0] mnemonic_code;
		logic [MODE_W-1:0] mode_code;
		logic [OPND_W-1:0] operand_value;
		logic [LEN_W-1:0]  byte_length;
	} record_t;

	function automatic op_entry_t mk(input mnemonic_t mnem,
			input logic [MODE_W-1:0] mode);
		op_entry_t e;
		e.known = 1'b1;
		e.mnem  = mnem;
		e.mode  = mode;
		return e;
	endfunction

	// Length of an instruction from its addressing mode.
	function automatic logic [LEN_W-1:0] mode_len(input logic [MODE_W-1:0] mode);
		logic [LEN_W-1:0] len;
		case (mode) inside
			MD_ACC, MD_IMP:                 len = LEN_ONE;
			MD_ABS, MD_ABX, MD_ABY, MD_IND: len = LEN_THREE;
			default:                        len = LEN_TWO;
		endcase
		return len;
	endfunction

	// Opcode ROM of the documented instruction set.
	function automatic op_entry_t op_lookup(input logic [BYTE_W-1:0] code);
		op_entry_t e;
		e = '0;
		unique case (code)
			8'h69: e = mk(MN_ADC, MD_IMM);  8'h6D: e = mk(MN_ADC, MD_ABS);
			8'h65: e = mk(MN_ADC, MD_ZP);   8'h61: e = mk(MN_ADC, MD_IZX);
			8'h71: e = mk(MN_ADC, MD_IZY);  8'h75: e = mk(MN_ADC, MD_ZPX);
			8'h7D: e = mk(MN_ADC, MD_ABX);  8'h79: e = mk(MN_ADC, MD_ABY);
			8'h29: e = mk(MN_AND, MD_IMM);  8'h2D: e = mk(MN_AND, MD_ABS);
			8'h25: e = mk(MN_AND, MD_ZP);   8'h21: e = mk(MN_AND, MD_IZX);
			8'h31: e = mk(MN_AND, MD_IZY);  8'h35: e = mk(MN_AND, MD_ZPX);
			8'h3D: e = mk(MN_AND, MD_ABX);  8'h39: e = mk(MN_AND, MD_ABY);
			8'h0E: e = mk(MN_ASL, MD_ABS);  8'h06: e = mk(MN_ASL, MD_ZP);
			8'h0A: e = mk(MN_ASL, MD_ACC);  8'h16: e = mk(MN_ASL, MD_ZPX);
			8'h1E: e = mk(MN_ASL, MD_ABX);
			8'h90: e = mk(MN_BCC, MD_REL);  8'hB0: e = mk(MN_BCS, MD_REL);
			8'hF0: e = mk(MN_BEQ, MD_REL);
			8'h2C: e = mk(MN_BIT, MD_ABS);  8'h24: e = mk(MN_BIT, MD_ZP);
			8'h30: e = mk(MN_BMI, MD_REL);  8'hD0: e = mk(MN_BNE, MD_REL);
			8'h10: e = mk(MN_BPL, MD_REL);  8'h00: e = mk(MN_BRK, MD_IMP);
			8'h50: e = mk(MN_BVC, MD_REL);  8'h70: e = mk(MN_BVS, MD_REL);
			8'h18: e = mk(MN_CLC, MD_IMP);  8'hD8: e = mk(MN_CLD, MD_IMP);
			8'h58: e = mk(MN_CLI, MD_IMP);  8'hB8: e = mk(MN_CLV, MD_IMP);
			8'hC9: e = mk(MN_CMP, MD_IMM);  8'hCD: e = mk(MN_CMP, MD_ABS);
			8'hC5: e = mk(MN_CMP, MD_ZP);   8'hC1: e = mk(MN_CMP, MD_IZX);
			8'hD1: e = mk(MN_CMP, MD_IZY);  8'hD5: e = mk(MN_CMP, MD_ZPX);
			8'hDD: e = mk(MN_CMP, MD_ABX);  8'hD9: e = mk(MN_CMP, MD_ABY);
			8'hE0: e = mk(MN_CPX, MD_IMM);  8'hEC: e = mk(MN_CPX, MD_ABS);
			8'hE4: e = mk(MN_CPX, MD_ZP);
			8'hC0: e = mk(MN_CPY, MD_IMM);  8'hCC: e = mk(MN_CPY, MD_ABS);
			8'hC4: e = mk(MN_CPY, MD_ZP);
			8'hCE: e = mk(MN_DEC, MD_ABS);  8'hC6: e = mk(MN_DEC, MD_ZP);
			8'hD6: e = mk(MN_DEC, MD_ZPX);  8'hDE: e = mk(MN_DEC, MD_ABX);
			8'hCA: e = mk(MN_DEX, MD_IMP);  8'h88: e = mk(MN_DEY, MD_IMP);
			8'h49: e = mk(MN_EOR, MD_IMM);  8'h4D: e = mk(MN_EOR, MD_ABS);
			8'h45: e = mk(MN_EOR, MD_ZP);   8'h41: e = mk(MN_EOR, MD_IZX);
			8'h51: e = mk(MN_EOR, MD_IZY);  8'h55: e = mk(MN_EOR, MD_ZPX);
			8'h5D: e = mk(MN_EOR, MD_ABX);  8'h59: e = mk(MN_EOR, MD_ABY);
			8'hEE: e = mk(MN_INC, MD_ABS);  8'hE6: e = mk(MN_INC, MD_ZP);
			8'hF6: e = mk(MN_INC, MD_ZPX);  8'hFE: e = mk(MN_INC, MD_ABX);
			8'hE8: e = mk(MN_INX, MD_IMP);  8'hC8: e = mk(MN_INY, MD_IMP);
			8'h4C: e = mk(MN_JMP, MD_ABS);  8'h6C: e = mk(MN_JMP, MD_IND);
			8'h20: e = mk(MN_JSR, MD_ABS);
			8'hA9: e = mk(MN_LDA, MD_IMM);  8'hAD: e = mk(MN_LDA, MD_ABS);
			8'hA5: e = mk(MN_LDA, MD_ZP);   8'hA1: e = mk(MN_LDA, MD_IZX);
			8'hB1: e = mk(MN_LDA, MD_IZY);  8'hB5: e = mk(MN_LDA, MD_ZPX);
			8'hBD: e = mk(MN_LDA, MD_ABX);  8'hB9: e = mk(MN_LDA, MD_ABY);
			8'hA2: e = mk(MN_LDX, MD_IMM);  8'hAE: e = mk(MN_LDX, MD_ABS);
			8'hA6: e = mk(MN_LDX, MD_ZP);   8'hBE: e = mk(MN_LDX, MD_ABY);
			8'hB6: e = mk(MN_LDX, MD_ZPY);
			8'hA0: e = mk(MN_LDY, MD_IMM);  8'hAC: e = mk(MN_LDY, MD_ABS);
			8'hA4: e = mk(MN_LDY, MD_ZP);   8'hB4: e = mk(MN_LDY, MD_ZPX);
			8'hBC: e = mk(MN_LDY, MD_ABX);
			8'h4E: e = mk(MN_LSR, MD_ABS);  8'h46: e = mk(MN_LSR, MD_ZP);
			8'h4A: e = mk(MN_LSR, MD_ACC);  8'h56: e = mk(MN_LSR, MD_ZPX);
			8'h5E: e = mk(MN_LSR, MD_ABX);
			8'hEA: e = mk(MN_NOP, MD_IMP);
			8'h09: e = mk(MN_ORA, MD_IMM);  8'h0D: e = mk(MN_ORA, MD_ABS);
			8'h05: e = mk(MN_ORA, MD_ZP);   8'h01: e = mk(MN_ORA, MD_IZX);
			8'h11: e = mk(MN_ORA, MD_IZY);  8'h15: e = mk(MN_ORA, MD_ZPX);
			8'h1D: e = mk(MN_ORA, MD_ABX);  8'h19: e = mk(MN_ORA, MD_ABY);
			8'h48: e = mk(MN_PHA, MD_IMP);  8'h08: e = mk(MN_PHP, MD_IMP);
			8'h68: e = mk(MN_PLA, MD_IMP);  8'h28: e = mk(MN_PLP, MD_IMP);
			8'h2E: e = mk(MN_ROL, MD_ABS);  8'h26: e = mk(MN_ROL, MD_ZP);
			8'h2A: e = mk(MN_ROL, MD_ACC);  8'h36: e = mk(MN_ROL, MD_ZPX);
			8'h3E: e = mk(MN_ROL, MD_ABX);
			8'h6E: e = mk(MN_ROR, MD_ABS);  8'h66: e = mk(MN_ROR, MD_ZP);
			8'h6A: e = mk(MN_ROR, MD_ACC);  8'h76: e = mk(MN_ROR, MD_ZPX);
			8'h7E: e = mk(MN_ROR, MD_ABX);
			8'h40: e = mk(MN_RTI, MD_IMP);  8'h60: e = mk(MN_RTS, MD_IMP);
			8'hE9: e = mk(MN_SBC, MD_IMM);  8'hED: e = mk(MN_SBC, MD_ABS);
			8'hE5: e = mk(MN_SBC, MD_ZP);   8'hE1: e = mk(MN_SBC, MD_IZX);
			8'hF1: e = mk(MN_SBC, MD_IZY);  8'hF5: e = mk(MN_SBC, MD_ZPX);
			8'hFD: e = mk(MN_SBC, MD_ABX);  8'hF9: e = mk(MN_SBC, MD_ABY);
			8'h38: e = mk(MN_SEC, MD_IMP);  8'hF8: e = mk(MN_SED, MD_IMP);
			8'h78: e = mk(MN_SEI, MD_IMP);
			8'h8D: e = mk(MN_STA, MD_ABS);  8'h85: e = mk(MN_STA, MD_ZP);
			8'h81: e = mk(MN_STA, MD_IZX);  8'h91: e = mk(MN_STA, MD_IZY);
			8'h95: e = mk(MN_STA, MD_ZPX);  8'h9D: e = mk(MN_STA, MD_ABX);
			8'h99: e = mk(MN_STA, MD_ABY);
			8'h8E: e = mk(MN_STX, MD_ABS);  8'h86: e = mk(MN_STX, MD_ZP);
			8'h96: e = mk(MN_STX, MD_ZPY);
			8'h8C: e = mk(MN_STY, MD_ABS);  8'h84: e = mk(MN_STY, MD_ZP);
			8'h94: e = mk(MN_STY, MD_ZPX);
			8'hAA: e = mk(MN_TAX, MD_IMP);  8'hA8: e = mk(MN_TAY, MD_IMP);
			8'hBA: e = mk(MN_TSX, MD_IMP);  8'h8A: e = mk(MN_TXA, MD_IMP);
			8'h9A: e = mk(MN_TXS, MD_IMP);  8'h98: e = mk(MN_TYA, MD_IMP);
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

/* sv/osf6502_stream_if.sv */
interface osf6502_stream_if import osf6502_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] stream_byte;
	logic              stream_end;

	modport source (output valid, output stream_byte, output stream_end, input ready);
	modport sink (input valid, input stream_byte, input stream_end, output ready);
endinterface

/* sv/osf6502_record_if.sv */
interface osf6502_record_if import osf6502_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              record_kind;
	logic [BYTE_W-1:0] opcode_byte;
	logic [MNEM_W-1:0] mnemonic_code;
	logic [MODE_W-1:0] mode_code;
	logic [OPND_W-1:0] operand_value;
	logic [LEN_W-1:0]  byte_length;

	modport source (output valid, output record_kind, output opcode_byte,
		output mnemonic_code, output mode_code, output operand_value,
		output byte_length, input ready);
	modport sink (input valid, input record_kind, input opcode_byte,
		input mnemonic_code, input mode_code, input operand_value,
		input byte_length, output ready);
endinterface

/* sv/opcode_stream_framer_6502_top.sv */
// Splits a byte stream into documented 6502 instructions. Each request on the
// stream channel carries one byte and an end-of-image flag; an opcode byte is
// looked up in a constant opcode ROM, operand bytes are collected, and one
// record per complete instruction leaves on the record channel with the
// operand little-endian. An undocumented opcode leaves at once as a one-byte
// data record, and an instruction cut short by the end flag is dropped. The
// block takes one byte per clock cycle unless stalled: a byte sits in the input
// register while the ROM lookup and the framing counter decide its record,
// which then waits in the output register. A byte's record passes through the
// input register and then the output register before it is presented on the
// record channel; backpressure on the record channel stalls the input only when
// both registers are full and the waiting record is not taken.
`include "assert_macros.svh"

module opcode_stream_framer_6502_top import osf6502_pkg::*; (
	input logic clk,
	input logic arst_n,
	osf6502_stream_if.sink stream,
	osf6502_record_if.source record
);

	// Input register.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              end_s1;

	// Framing state.
	logic [1:0]        need_q;
	logic [BYTE_W-1:0] held_op_q;
	logic [MNEM_W-1:0] held_mnem_q;
	logic [MODE_W-1:0] held_mode_q;
	logic [BYTE_W-1:0] held_low_q;

	// Output register.
	logic    out_valid_q;
	record_t out_q;

	logic       advance;
	op_entry_t  look;
	logic [LEN_W-1:0] look_len;
	logic [LEN_W-1:0] held_len;
	logic       emit;
	record_t    rec;
	logic [1:0] need_next;
	logic       capture_op;
	logic       capture_low;

	// The stage moves on whenever the output register is free or being taken.
	assign advance      = valid_s1 && (!out_valid_q || record.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.stream_byte;
			end_s1  <= stream.stream_end;
		end
	end

	// Decode of the byte in the input register against the framing state.
	assign look     = op_lookup(byte_s1);
	assign look_len = mode_len(look.mode);
	assign held_len = mode_len(held_mode_q);

	always_comb begin
		emit        = 1'b0;
		need_next   = need_q;
		capture_op  = 1'b0;
		capture_low = 1'b0;
		rec         = '0;
		rec.byte_length = LEN_ONE;
		unique case (need_q)
			NEED_OPCODE: begin
				rec.opcode_byte = byte_s1;
				if (!look.known) begin
					emit            = 1'b1;
					rec.record_kind = KIND_DATA;
				end else if (look_len == LEN_ONE) begin
					emit              = 1'b1;
					rec.record_kind   = KIND_INSTR;
					rec.mnemonic_code = look.mnem;
					rec.mode_code     = look.mode;
				end else if (!end_s1) begin
					capture_op = 1'b1;
					need_next  = look_len - LEN_ONE;
				end
			end
			NEED_TWO: begin
				capture_low = 1'b1;
				need_next   = end_s1 ? NEED_OPCODE : NEED_ONE;
			end
			NEED_ONE: begin
				emit              = 1'b1;
				need_next         = NEED_OPCODE;
				rec.record_kind   = KIND_INSTR;
				rec.opcode_byte   = held_op_q;
				rec.mnemonic_code = held_mnem_q;
				rec.mode_code     = held_mode_q;
				rec.byte_length   = held_len;
				if (held_len == LEN_THREE) begin
					rec.operand_value = {byte_s1, held_low_q};
				end else begin
					rec.operand_value = {{(OPND_W-BYTE_W){1'b0}}, byte_s1};
				end
			end
			default: begin
				need_next = NEED_OPCODE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= NEED_OPCODE;
		end else if (advance) begin
			need_q <= need_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && capture_op) begin
			held_op_q   <= byte_s1;
			held_mnem_q <= look.mnem;
			held_mode_q <= look.mode;
		end
		if (advance && capture_low) begin
			held_low_q <= byte_s1;
		end
	end

	// Output register holds a record until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (record.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= rec;
		end
	end

	assign record.valid         = out_valid_q;
	assign record.record_kind   = out_q.record_kind;
	assign record.opcode_byte   = out_q.opcode_byte;
	assign record.mnemonic_code = out_q.mnemonic_code;
	assign record.mode_code     = out_q.mode_code;
	assign record.operand_value = out_q.operand_value;
	assign record.byte_length   = out_q.byte_length;

	// The framing counter never reaches three.
	`ASSERT_NEVER(a_need_range, clk, arst_n, need_q == 2'd3)
	// A byte that ends the image always leaves the framer awaiting an opcode.
	`ASSERT_AT(a_end_resets, clk, arst_n, (advance && end_s1) |=> (need_q == NEED_OPCODE))
	// Data records cover one byte and carry no decode.
	`ASSERT_AT(a_data_shape, clk, arst_n,
		(out_valid_q && out_q.record_kind == KIND_DATA) |->
		(out_q.byte_length == LEN_ONE && out_q.mnemonic_code == '0 &&
		out_q.mode_code == '0 && out_q.operand_value == '0))
	// An instruction record covers as many bytes as its mode demands.
	`ASSERT_AT(a_instr_len, clk, arst_n,
		(out_valid_q && out_q.record_kind == KIND_INSTR) |->
		(out_q.byte_length == mode_len(out_q.mode_code)))

endmodule
